[design/bdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded distribution counter package
// Sizes, modulus, state and control types, and the limit clamp shared by the
// counter modules.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int MAX_TOTAL = 4096;

    localparam int W_FIELD = 13;
    localparam int W_VAL   = 30;
    localparam int W_WIDX  = $clog2(MAX_TOTAL + 1);
    localparam int W_CNT   = $clog2(MAX_TOTAL + 2);

    localparam int W_TDATA_IN  = ((W_FIELD + 7) / 8) * 8;
    localparam int W_TDATA_OUT = ((W_VAL + 7) / 8) * 8;

    localparam logic [W_VAL-1:0] MODULUS  = W_VAL'(1000000007);
    localparam logic [W_CNT-1:0] CNT_LAST = W_CNT'(MAX_TOTAL + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic              prefix_act;
        logic              update_act;
        logic [W_CNT-1:0]  cnt;
        logic              row_clear;
        logic [W_WIDX-1:0] limit;
        logic [W_WIDX-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic load;
        logic last;
    } t_load;

    function automatic logic [W_WIDX-1:0] clamp_idx(input logic [W_FIELD-1:0] v);
        logic [W_WIDX-1:0] r;
        if (int'(v) > MAX_TOTAL) begin
            r = W_WIDX'(MAX_TOTAL);
        end else begin
            r = W_WIDX'(v);
        end
        return r;
    endfunction

endpackage

[design/bdc_mod_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular add/subtract unit
// Shared unit for both row passes: (a + b) or (a - b) modulo the prime, for
// operands already reduced.
// ----------------------------------------------------------------------------
module bdc_mod_alu (
    input  bdc_pkg::t_alu_op           i_op,
    input  logic [bdc_pkg::W_VAL-1:0]  i_a,
    input  logic [bdc_pkg::W_VAL-1:0]  i_b,
    output logic [bdc_pkg::W_VAL-1:0]  o_y
);

    logic [bdc_pkg::W_VAL-1:0] b_eff;
    logic [bdc_pkg::W_VAL:0]   sum;
    logic [bdc_pkg::W_VAL:0]   mod_ext;

    always_comb begin
        b_eff   = (i_op == bdc_pkg::ALU_SUB) ? (bdc_pkg::MODULUS - i_b) : i_b;
        sum     = {1'b0, i_a} + {1'b0, b_eff};
        mod_ext = {1'b0, bdc_pkg::MODULUS};
        if (sum >= mod_ext) begin
            o_y = bdc_pkg::W_VAL'(sum - mod_ext);
        end else begin
            o_y = bdc_pkg::W_VAL'(sum);
        end
    end

endmodule

[design/bdc_row_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row engine
// Holds the count row and the prefix row, runs the prefix pass and the update
// pass through the shared modular unit, and captures the count for the target.
// ----------------------------------------------------------------------------
module bdc_row_engine (
    input  logic                       i_clk,
    input  bdc_pkg::t_ctl              i_ctl,
    output logic [bdc_pkg::W_VAL-1:0]  o_result
);

    logic [bdc_pkg::W_VAL-1:0] r_ways_mem [0:bdc_pkg::MAX_TOTAL];
    logic [bdc_pkg::W_VAL-1:0] r_pre_mem  [0:bdc_pkg::MAX_TOTAL+1];

    logic [bdc_pkg::W_VAL-1:0] r_ways_rd;
    logic [bdc_pkg::W_VAL-1:0] r_pre_hi;
    logic [bdc_pkg::W_VAL-1:0] r_pre_lo;
    logic [bdc_pkg::W_VAL-1:0] r_acc;
    logic [bdc_pkg::W_VAL-1:0] r_result;

    logic [bdc_pkg::W_CNT-1:0] cnt_prev;
    logic [bdc_pkg::W_CNT-1:0] pre_hi_addr;
    logic [bdc_pkg::W_CNT-1:0] pre_lo_addr;
    logic [bdc_pkg::W_CNT-1:0] limit_ext;
    logic                      not_last;
    logic [bdc_pkg::W_VAL-1:0] ways_seed;
    logic [bdc_pkg::W_VAL-1:0] pre_wdata;
    bdc_pkg::t_alu_op          alu_op;
    logic [bdc_pkg::W_VAL-1:0] alu_a;
    logic [bdc_pkg::W_VAL-1:0] alu_b;
    logic [bdc_pkg::W_VAL-1:0] alu_y;

    always_comb begin
        cnt_prev    = i_ctl.cnt - bdc_pkg::W_CNT'(1);
        pre_hi_addr = i_ctl.cnt + bdc_pkg::W_CNT'(1);
        limit_ext   = bdc_pkg::W_CNT'(i_ctl.limit);
        pre_lo_addr = (i_ctl.cnt > limit_ext) ? (i_ctl.cnt - limit_ext) : '0;
        not_last    = (i_ctl.cnt != bdc_pkg::CNT_LAST);
        // empty row: one way for total zero
        if (i_ctl.row_clear) begin
            ways_seed = (i_ctl.cnt == bdc_pkg::W_CNT'(1)) ? bdc_pkg::W_VAL'(1) : '0;
        end else begin
            ways_seed = r_ways_rd;
        end
        alu_op    = i_ctl.update_act ? bdc_pkg::ALU_SUB : bdc_pkg::ALU_ADD;
        alu_a     = i_ctl.update_act ? r_pre_hi : r_acc;
        alu_b     = i_ctl.update_act ? r_pre_lo : ways_seed;
        pre_wdata = (i_ctl.cnt == '0) ? '0 : alu_y;
    end

    bdc_mod_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.prefix_act) begin
            if (not_last) begin
                r_ways_rd <= r_ways_mem[i_ctl.cnt[bdc_pkg::W_WIDX-1:0]];
            end
            r_pre_mem[i_ctl.cnt] <= pre_wdata;
            r_acc                <= pre_wdata;
        end
        if (i_ctl.update_act) begin
            if (not_last) begin
                r_pre_hi <= r_pre_mem[pre_hi_addr];
                r_pre_lo <= r_pre_mem[pre_lo_addr];
            end
            if (i_ctl.cnt != '0) begin
                r_ways_mem[cnt_prev[bdc_pkg::W_WIDX-1:0]] <= alu_y;
                if (cnt_prev == bdc_pkg::W_CNT'(i_ctl.target)) begin
                    r_result <= alu_y;
                end
            end
        end
    end

    assign o_result = r_result;

endmodule

[design/bdc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pass sequencer
// Accepts one item, steps the row index through the prefix pass and the update
// pass, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bdc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [bdc_pkg::W_FIELD-1:0] i_share_limit,
    input  logic                        i_first_item,
    input  logic                        i_last_item,
    input  logic [bdc_pkg::W_FIELD-1:0] i_total_count,
    input  logic                        i_out_free,
    output logic                        o_in_ready,
    output bdc_pkg::t_ctl               o_ctl,
    output bdc_pkg::t_load              o_load
);

    bdc_pkg::t_state            r_state;
    bdc_pkg::t_state            n_state;
    logic [bdc_pkg::W_CNT-1:0]  r_cnt;
    logic                       r_row_clear;
    logic [bdc_pkg::W_WIDX-1:0] r_limit;
    logic [bdc_pkg::W_WIDX-1:0] r_target;
    logic                       r_last;
    logic                       accept;
    logic                       cnt_end;

    assign accept  = (r_state == bdc_pkg::ST_IDLE) && i_in_valid;
    assign cnt_end = (r_cnt == bdc_pkg::CNT_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bdc_pkg::ST_PREFIX;
            end
            bdc_pkg::ST_PREFIX: begin
                if (cnt_end) n_state = bdc_pkg::ST_UPDATE;
            end
            bdc_pkg::ST_UPDATE: begin
                if (cnt_end) n_state = bdc_pkg::ST_DONE;
            end
            bdc_pkg::ST_DONE: begin
                if (i_out_free) n_state = bdc_pkg::ST_IDLE;
            end
            default: n_state = bdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_ctl.prefix_act  = 1'b0;
        o_ctl.update_act  = 1'b0;
        o_load.load       = 1'b0;
        unique case (r_state)
            bdc_pkg::ST_IDLE:   o_in_ready       = 1'b1;
            bdc_pkg::ST_PREFIX: o_ctl.prefix_act = 1'b1;
            bdc_pkg::ST_UPDATE: o_ctl.update_act = 1'b1;
            bdc_pkg::ST_DONE:   o_load.load      = i_out_free;
            default:            o_in_ready       = 1'b0;
        endcase
        o_ctl.cnt       = r_cnt;
        o_ctl.row_clear = r_row_clear;
        o_ctl.limit     = r_limit;
        o_ctl.target    = r_target;
        o_load.last     = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_row_clear <= 1'b1;
        end else begin
            r_state <= n_state;
            if (accept || cnt_end) begin
                r_cnt <= '0;
            end else if ((r_state == bdc_pkg::ST_PREFIX) || (r_state == bdc_pkg::ST_UPDATE)) begin
                r_cnt <= r_cnt + bdc_pkg::W_CNT'(1);
            end
            if (accept && i_first_item) begin
                r_row_clear <= 1'b1;
            end else if ((r_state == bdc_pkg::ST_UPDATE) && cnt_end) begin
                r_row_clear <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_limit  <= bdc_pkg::clamp_idx(i_share_limit);
            r_target <= bdc_pkg::clamp_idx(i_total_count);
            r_last   <= i_last_item;
        end
    end

endmodule

[design/bounded_distribution_counter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded distribution counter
// Counts, modulo 1000000007, the ways to share total_count units among the
// recipients seen so far, each taking at most its own limit.
//
// Channel  Dir  Signals                     Content
// s_axis   in   tvalid tready tdata tuser   tdata: share_limit; tuser: first_item;
//                tlast                       tlast: last_item
// m_axis   out  tvalid tready tdata tlast   tdata: way_count; tlast: final_result
// cfg      in   i_cfg_wr_en i_cfg_wr_data   total_count
//
// Each item runs the prefix pass and the update pass over the row memories,
// one entry and one modular add or subtract per cycle through the shared
// unit.
// Reset marks the row as empty; there is no clearing pass after reset.
// A new item is taken while a result waits in the output register, but not
// while a finished result holds in the sequencer for the register to be free.
// ----------------------------------------------------------------------------
module bounded_distribution_counter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdc_pkg::W_TDATA_IN-1:0]  s_axis_tdata,  // share_limit
    input  logic                            s_axis_tuser,  // first_item
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdc_pkg::W_TDATA_OUT-1:0] m_axis_tdata,  // way_count
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_wr_en,
    input  logic [bdc_pkg::W_FIELD-1:0]     i_cfg_wr_data
);

    logic [bdc_pkg::W_FIELD-1:0] r_total_count;
    logic                        r_m_valid;
    logic [bdc_pkg::W_VAL-1:0]   r_way_count;
    logic                        r_final;
    logic                        out_free;
    bdc_pkg::t_ctl               ctl;
    bdc_pkg::t_load              load;
    logic [bdc_pkg::W_VAL-1:0]   result;

    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_count <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total_count <= i_cfg_wr_data;
            end
            if (load.load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load.load) begin
            r_way_count <= result;
            r_final     <= load.last;
        end
    end

    bdc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_share_limit (s_axis_tdata[bdc_pkg::W_FIELD-1:0]),
        .i_first_item  (s_axis_tuser),
        .i_last_item   (s_axis_tlast),
        .i_total_count (r_total_count),
        .i_out_free    (out_free),
        .o_in_ready    (s_axis_tready),
        .o_ctl         (ctl),
        .o_load        (load)
    );

    bdc_row_engine u_engine (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .o_result (result)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(bdc_pkg::W_TDATA_OUT - bdc_pkg::W_VAL){1'b0}}, r_way_count};
    assign m_axis_tlast  = r_final;

endmodule

[design/bdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded distribution counter port checker
// Watches the top-level ports for output hold, busy behavior and result range.
// ----------------------------------------------------------------------------
module bdc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bdc_pkg::W_TDATA_OUT-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result item appeared without work in progress");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata < bdc_pkg::W_TDATA_OUT'(bdc_pkg::MODULUS)))
        else $error("way count not reduced");

endmodule

bind bounded_distribution_counter_unit bdc_checker u_bdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[test/tb_bounded_distribution_counter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded distribution counter testbench
// Streams recipient limits into the counter, predicts each way count with a
// row-based model of its own, and checks every result item in order. Runs
// directed cases for the field extremes and set boundaries, then random sets
// with random idling on both sides, then a steady stream with no idling.
// ----------------------------------------------------------------------------
module tb_bounded_distribution_counter_unit;

    localparam int ITEM_CYCLES = 2 * (bdc_pkg::MAX_TOTAL + 2) + 2;
    localparam int QUIET_LIMIT = 5 * ITEM_CYCLES;

    typedef struct {
        logic [bdc_pkg::W_VAL-1:0] way_count;
        logic                      final_result;
    } t_count_item;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            s_axis_tvalid  = 1'b0;
    logic                            s_axis_tready;
    logic [bdc_pkg::W_TDATA_IN-1:0]  s_axis_tdata   = '0;   // share_limit
    logic                            s_axis_tuser   = 1'b0; // first_item
    logic                            s_axis_tlast   = 1'b0; // last_item
    logic                            m_axis_tvalid;
    logic                            m_axis_tready  = 1'b0;
    logic [bdc_pkg::W_TDATA_OUT-1:0] m_axis_tdata;          // way_count
    logic                            m_axis_tlast;          // final_result
    logic                            i_cfg_wr_en    = 1'b0;
    logic [bdc_pkg::W_FIELD-1:0]     i_cfg_wr_data  = '0;   // total_count

    logic [bdc_pkg::W_VAL-1:0]   ways_by_total [0:bdc_pkg::MAX_TOTAL];
    logic [bdc_pkg::W_VAL-1:0]   running_sum   [0:bdc_pkg::MAX_TOTAL+1];
    logic [bdc_pkg::W_FIELD-1:0] total_setting = '0;
    t_count_item                 pending_counts[$];

    bit idle_on      = 1'b0;
    int fail_count   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    bounded_distribution_counter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    function automatic logic [bdc_pkg::W_VAL-1:0] mod_add(
            input logic [bdc_pkg::W_VAL-1:0] a,
            input logic [bdc_pkg::W_VAL-1:0] b);
        logic [bdc_pkg::W_VAL:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, bdc_pkg::MODULUS}) begin
            s = s - {1'b0, bdc_pkg::MODULUS};
        end
        return s[bdc_pkg::W_VAL-1:0];
    endfunction

    function automatic void empty_set();
        for (int t = 0; t <= bdc_pkg::MAX_TOTAL; t++) begin
            ways_by_total[t] = '0;
        end
        ways_by_total[0] = bdc_pkg::W_VAL'(1);
    endfunction

    // Add one recipient to the row and queue the count for the current total.
    function automatic void apply_recipient(input logic [bdc_pkg::W_FIELD-1:0] limit_in,
                                            input logic first, input logic last);
        int unsigned lim;
        int unsigned k;
        int unsigned lo;
        t_count_item want;
        lim = 32'(limit_in);
        if (lim > bdc_pkg::MAX_TOTAL) begin
            lim = bdc_pkg::MAX_TOTAL;
        end
        k = 32'(total_setting);
        if (k > bdc_pkg::MAX_TOTAL) begin
            k = bdc_pkg::MAX_TOTAL;
        end
        if (first) begin
            empty_set();
        end
        running_sum[0] = '0;
        for (int unsigned t = 1; t <= bdc_pkg::MAX_TOTAL + 1; t++) begin
            running_sum[t] = mod_add(running_sum[t-1], ways_by_total[t-1]);
        end
        for (int unsigned t = 0; t <= bdc_pkg::MAX_TOTAL; t++) begin
            lo = (t > lim) ? t - lim : 0;
            ways_by_total[t] = mod_add(running_sum[t+1],
                                       bdc_pkg::MODULUS - running_sum[lo]);
        end
        want.way_count    = ways_by_total[k];
        want.final_result = last;
        pending_counts.push_back(want);
    endfunction

    task automatic send_item(input logic [bdc_pkg::W_FIELD-1:0] limit, input logic first,
                             input logic last);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bdc_pkg::W_TDATA_IN'(limit);
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_recipient(limit, first, last);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [bdc_pkg::W_FIELD-1:0] value);
        wait_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        total_setting = value;
    endtask

    function automatic logic [bdc_pkg::W_FIELD-1:0] pick_total();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return bdc_pkg::W_FIELD'($urandom_range(0, 40));
        end else if (sel < 9) begin
            return bdc_pkg::W_FIELD'($urandom_range(0, bdc_pkg::MAX_TOTAL));
        end
        return bdc_pkg::W_FIELD'($urandom_range(0, 8191));
    endfunction

    function automatic logic [bdc_pkg::W_FIELD-1:0] pick_limit();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return bdc_pkg::W_FIELD'($urandom_range(0, 20));
        end else if (sel < 8) begin
            return bdc_pkg::W_FIELD'($urandom_range(0, 32'(total_setting) + 2));
        end
        return bdc_pkg::W_FIELD'($urandom_range(0, 8191));
    endfunction

    // Reset row acts as the empty set when no first item has come.
    task automatic test_reset_row();
        send_item(bdc_pkg::W_FIELD'(0), 1'b0, 1'b0);
        send_item(bdc_pkg::W_FIELD'(3), 1'b0, 1'b1);
    endtask

    task automatic test_limit_extremes();
        write_total(bdc_pkg::W_FIELD'(5));
        send_item(bdc_pkg::W_FIELD'(2), 1'b1, 1'b0);
        send_item(bdc_pkg::W_FIELD'(3), 1'b0, 1'b0);
        send_item(bdc_pkg::W_FIELD'(8191), 1'b0, 1'b1);
        send_item(bdc_pkg::W_FIELD'(0), 1'b1, 1'b1);
        send_item(bdc_pkg::W_FIELD'(5), 1'b1, 1'b0);
        send_item(bdc_pkg::W_FIELD'(bdc_pkg::MAX_TOTAL), 1'b0, 1'b1);
    endtask

    task automatic test_total_extremes();
        write_total(bdc_pkg::W_FIELD'(bdc_pkg::MAX_TOTAL));
        send_item(bdc_pkg::W_FIELD'(bdc_pkg::MAX_TOTAL), 1'b1, 1'b0);
        send_item(bdc_pkg::W_FIELD'(0), 1'b0, 1'b0);
        send_item(bdc_pkg::W_FIELD'(1), 1'b0, 1'b1);
        write_total(bdc_pkg::W_FIELD'(8191));
        send_item(bdc_pkg::W_FIELD'(5000), 1'b1, 1'b0);
        send_item(bdc_pkg::W_FIELD'(8191), 1'b0, 1'b1);
        write_total(bdc_pkg::W_FIELD'(0));
        send_item(bdc_pkg::W_FIELD'(0), 1'b1, 1'b1);
    endtask

    // Change the total mid-set, then keep adding after the last item.
    task automatic test_set_continuation();
        write_total(bdc_pkg::W_FIELD'(3));
        send_item(bdc_pkg::W_FIELD'(2), 1'b1, 1'b0);
        send_item(bdc_pkg::W_FIELD'(2), 1'b0, 1'b0);
        write_total(bdc_pkg::W_FIELD'(7));
        send_item(bdc_pkg::W_FIELD'(2), 1'b0, 1'b1);
        send_item(bdc_pkg::W_FIELD'(1), 1'b0, 1'b0);
        send_item(bdc_pkg::W_FIELD'(4), 1'b0, 1'b1);
    endtask

    task automatic test_random_sets();
        int unsigned sent;
        int unsigned set_len;
        bit          broken;
        logic        first;
        logic        last;
        idle_on = 1'b1;
        sent    = 0;
        while (sent < 65) begin
            if ($urandom_range(0, 2) == 0) begin
                write_total(pick_total());
            end
            set_len = $urandom_range(1, 6);
            broken  = ($urandom_range(0, 5) == 0);
            for (int unsigned i = 0; i < set_len; i++) begin
                first = (i == 0);
                last  = (i == set_len - 1);
                if (broken) begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                send_item(pick_limit(), first, last);
            end
            sent += set_len;
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_total(bdc_pkg::W_FIELD'($urandom_range(1, 30)));
        for (int unsigned i = 0; i < 15; i++) begin
            send_item(pick_limit(), (i % 5) == 0, (i % 5) == 4);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= $urandom_range(1, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_counts
        t_count_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                $error("way_count: expected none, got %0d", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_counts.pop_front();
                if (m_axis_tdata !== bdc_pkg::W_TDATA_OUT'(want.way_count)) begin
                    $error("way_count: expected %0d, got %0d", want.way_count,
                           m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.final_result) begin
                    $error("final_result: expected %0d, got %0d",
                           want.final_result, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                     || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        empty_set();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_row();
        test_limit_extremes();
        test_total_extremes();
        test_set_continuation();
        test_random_sets();
        test_steady_stream();
        wait_drain();
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/bdc_pkg.sv
design/bdc_mod_alu.sv
design/bdc_row_engine.sv
design/bdc_ctrl.sv
design/bounded_distribution_counter_unit.sv
design/bdc_checker.sv
test/tb_bounded_distribution_counter_unit.sv
